// ===== sv/rlbd_pkg.sv =====
// rlbd_pkg: shared types and constants of the run-length block decoder
// holds the transaction structs of both ports, the front-to-back command and queue sizing
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package rlbd_pkg;

    // depth of the command queue between parser and result stage
    localparam int unsigned Q_DEPTH = 4;
    localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
    localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

    // one encoded input transaction
    typedef struct packed {
        logic [7:0] encoded_byte;
        logic       last_in_buffer;
    } in_item_t;

    // one decoded result transaction
    typedef struct packed {
        logic [7:0]  data_value;
        logic [31:0] repeat_count;
        logic        buffer_end;
    } out_item_t;

    // classified command handed from the parser to the result stage
    typedef struct packed {
        logic        is_run;
        logic [7:0]  value;
        logic [31:0] run_length;
        logic        buffer_end;
    } cmd_t;

    // queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

`default_nettype wire

// ===== sv/rlbd_front.sv =====
// rlbd_front: byte-wise header parser, classifies each byte and emits commands
// depends on rlbd_pkg
`timescale 1ns / 1ps
`default_nettype none

module rlbd_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             accept,
    input  wire rlbd_pkg::in_item_t item,
    output logic                  cmd_valid,
    output rlbd_pkg::cmd_t        cmd
);
    import rlbd_pkg::*;

    // parse phase codes
    localparam logic [2:0] PH_FLAG = 3'd0;
    localparam logic [2:0] PH_LEN0 = 3'd1;
    localparam logic [2:0] PH_LEN1 = 3'd2;
    localparam logic [2:0] PH_LEN2 = 3'd3;
    localparam logic [2:0] PH_LEN3 = 3'd4;
    localparam logic [2:0] PH_LIT  = 3'd5;
    localparam logic [2:0] PH_RUNV = 3'd6;

    logic [2:0]  phase_reg, phase_next;
    logic        is_run_reg, is_run_next;
    logic [31:0] length_reg, length_next;
    logic [31:0] remaining_reg, remaining_next;
    logic [1:0]  lane;

    assign lane = 2'(phase_reg - PH_LEN0);

    // next state and command for the byte being accepted
    always_comb
    begin
        phase_next     = phase_reg;
        is_run_next    = is_run_reg;
        length_next    = length_reg;
        remaining_next = remaining_reg;
        cmd_valid      = 1'b0;
        cmd.is_run     = is_run_reg;
        cmd.value      = item.encoded_byte;
        cmd.run_length = length_reg;
        cmd.buffer_end = item.last_in_buffer;
        if (accept)
        begin
            unique case (phase_reg)
                PH_LEN0, PH_LEN1, PH_LEN2, PH_LEN3:
                begin
                    // little-endian length byte into its lane
                    length_next[{lane, 3'b000} +: 8] =
                        length_reg[{lane, 3'b000} +: 8] | item.encoded_byte;
                    if (phase_reg != PH_LEN3)
                    begin
                        phase_next = 3'(phase_reg + 3'd1);
                    end
                    else if (is_run_reg)
                    begin
                        phase_next = PH_RUNV;
                    end
                    else
                    begin
                        remaining_next = length_next;
                        phase_next     = (length_next == 32'd0) ? PH_FLAG : PH_LIT;
                    end
                end
                PH_LIT:
                begin
                    // literal byte, count one
                    cmd_valid      = 1'b1;
                    cmd.is_run     = 1'b0;
                    remaining_next = remaining_reg - 32'd1;
                    if (remaining_next == 32'd0)
                    begin
                        phase_next = PH_FLAG;
                    end
                end
                PH_RUNV:
                begin
                    // run value, dropped when the run is empty
                    cmd_valid  = (length_reg != 32'd0);
                    cmd.is_run = 1'b1;
                    phase_next = PH_FLAG;
                end
                default:
                begin
                    // flag byte, also the unused phase code
                    is_run_next    = (item.encoded_byte != 8'd0);
                    length_next    = 32'd0;
                    remaining_next = 32'd0;
                    phase_next     = PH_LEN0;
                end
            endcase
            // end of buffer returns the parser to the header
            if (item.last_in_buffer)
            begin
                phase_next     = PH_FLAG;
                remaining_next = 32'd0;
            end
        end
    end

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_FLAG;
            is_run_reg    <= 1'b0;
            length_reg    <= 32'd0;
            remaining_reg <= 32'd0;
        end
        else
        begin
            phase_reg     <= phase_next;
            is_run_reg    <= is_run_next;
            length_reg    <= length_next;
            remaining_reg <= remaining_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/rlbd_queue.sv =====
// rlbd_queue: small command queue between parser and result stage
// depends on rlbd_pkg
`timescale 1ns / 1ps
`default_nettype none

module rlbd_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            wr_en,
    input  wire rlbd_pkg::cmd_t  wr_data,
    input  wire logic            rd_en,
    output rlbd_pkg::cmd_t       rd_data,
    output rlbd_pkg::q_status_t  status
);
    import rlbd_pkg::*;

    cmd_t               mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0] count_reg, count_next;
    logic               do_wr, do_rd;

    assign status.full  = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_wr        = wr_en && !status.full;
    assign do_rd        = rd_en && !status.empty;
    assign rd_data      = mem_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = do_wr ? Q_PTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = do_rd ? Q_PTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg + Q_CNT_W'(do_wr) - Q_CNT_W'(do_rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage, no reset
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

// ===== sv/rlbd_back.sv =====
// rlbd_back: result stage, turns commands into value-plus-count results
// depends on rlbd_pkg
`timescale 1ns / 1ps
`default_nettype none

module rlbd_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire rlbd_pkg::q_status_t q_status,
    input  wire rlbd_pkg::cmd_t      q_data,
    output logic                     q_rd,
    input  wire logic                pop,
    output logic                     empty,
    output rlbd_pkg::out_item_t      decoded
);
    import rlbd_pkg::*;

    logic      out_valid_reg, out_valid_next;
    out_item_t out_reg, out_next;

    // take the next command when the output register is free or being drained
    assign q_rd = !q_status.empty && (!out_valid_reg || pop);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (q_rd)
        begin
            out_valid_next        = 1'b1;
            out_next.data_value   = q_data.value;
            out_next.repeat_count = q_data.is_run ? q_data.run_length : 32'd1;
            out_next.buffer_end   = q_data.buffer_end;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload, no reset
    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign empty   = !out_valid_reg;
    assign decoded = out_reg;

endmodule

`default_nettype wire

// ===== sv/run_length_block_decoder_core.sv =====
// run_length_block_decoder_core: top level of the run-length block decoder
// depends on rlbd_pkg, rlbd_front, rlbd_queue, rlbd_back
`timescale 1ns / 1ps
`default_nettype none

// Decodes a stream of length-prefixed blocks, one encoded byte per cycle. Each block is a
// flag byte and a 4-byte little-endian length; a zero flag is followed by that many literal
// bytes, each given as a result with count 1, any other flag by one value byte given as a
// single value-plus-count result. Empty blocks give nothing, and a byte marked last in buffer
// sends the parser back to the header. The input takes a byte every cycle while full is low;
// full rises only when the four-entry command queue behind the parser is full, which happens
// only while results are not popped. A result's command goes into the command queue when its
// byte is accepted and on into the output register once older results have left it, and results
// can be popped every cycle.
module run_length_block_decoder_core (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire rlbd_pkg::in_item_t encoded,
    output logic                    empty,
    input  wire logic               pop,
    output rlbd_pkg::out_item_t     decoded
);
    import rlbd_pkg::*;

    logic      accept;
    logic      cmd_valid;
    cmd_t      cmd;
    cmd_t      q_data;
    logic      q_rd;
    q_status_t q_status;

    assign full   = q_status.full;
    assign accept = push && !q_status.full;

    // parser
    rlbd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .item      (encoded),
        .cmd_valid (cmd_valid),
        .cmd       (cmd)
    );

    // command queue
    rlbd_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_valid),
        .wr_data (cmd),
        .rd_en   (q_rd),
        .rd_data (q_data),
        .status  (q_status)
    );

    // result stage
    rlbd_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_status (q_status),
        .q_data   (q_data),
        .q_rd     (q_rd),
        .pop      (pop),
        .empty    (empty),
        .decoded  (decoded)
    );

endmodule

`default_nettype wire

// ===== sv/rlbd_checker.sv =====
// rlbd_checker: port-level assertions for the run-length block decoder, with its bind
// depends on rlbd_pkg and run_length_block_decoder_core
`timescale 1ns / 1ps
`default_nettype none

module rlbd_checker (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                full,
    input wire logic                empty,
    input wire logic                pop,
    input wire rlbd_pkg::out_item_t decoded
);
    import rlbd_pkg::*;

    // a waiting result holds until popped
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(decoded)))
        else $error("result changed or vanished before pop");

    // every result repeats at least once
    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (decoded.repeat_count != 32'd0))
        else $error("result with zero repeat count");

    // reset leaves nothing queued and the input open
    a_reset_state: assert property (@(posedge clk)
        $past(!rst_n) |-> (empty && !full))
        else $error("block not idle after reset");

    // with no result waiting, the queue has not filled up
    a_full_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !empty)
        else $error("input stalled with no result waiting");

endmodule

bind run_length_block_decoder_core rlbd_checker u_rlbd_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .full    (full),
    .empty   (empty),
    .pop     (pop),
    .decoded (decoded)
);

`default_nettype wire

// ===== verif/run_length_block_decoder_checker.sv =====
// run_length_block_decoder_checker: watches both queue ports of the decoder, predicts results
// depends on rlbd_pkg for the transaction structs
`timescale 1ns / 1ps

module run_length_block_decoder_checker (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire logic                full,
    input  wire rlbd_pkg::in_item_t  encoded,
    input  wire logic                empty,
    input  wire logic                pop,
    input  wire rlbd_pkg::out_item_t decoded,
    output int unsigned              backlog,
    output int unsigned              error_count
);

    import rlbd_pkg::*;

    // where the parser stands within a block
    typedef enum logic [2:0] {
        EXPECT_FLAG,
        EXPECT_LEN0,
        EXPECT_LEN1,
        EXPECT_LEN2,
        EXPECT_LEN3,
        IN_LITERAL,
        EXPECT_RUN_VALUE
    } parse_phase_e;

    parse_phase_e phase;
    logic         run_block;
    logic [31:0]  block_len;
    logic [31:0]  literal_left;
    out_item_t    decoded_q[$];
    int unsigned  mismatches = 0;

    assign error_count = mismatches;

    // advance the parser by one encoded byte, queue the decoded transaction if one results
    task automatic decode_byte(input in_item_t it);
        out_item_t res;
        logic      produced;
        produced = 1'b0;
        res.data_value = it.encoded_byte;
        res.buffer_end = it.last_in_buffer;
        res.repeat_count = 32'd1;
        case (phase)
            EXPECT_LEN0:
            begin
                block_len[7:0] = it.encoded_byte;
                phase = EXPECT_LEN1;
            end
            EXPECT_LEN1:
            begin
                block_len[15:8] = it.encoded_byte;
                phase = EXPECT_LEN2;
            end
            EXPECT_LEN2:
            begin
                block_len[23:16] = it.encoded_byte;
                phase = EXPECT_LEN3;
            end
            EXPECT_LEN3:
            begin
                block_len[31:24] = it.encoded_byte;
                if (run_block)
                    phase = EXPECT_RUN_VALUE;
                else
                begin
                    literal_left = block_len;
                    phase = (block_len == 32'd0) ? EXPECT_FLAG : IN_LITERAL;
                end
            end
            IN_LITERAL:
            begin
                produced = 1'b1;
                literal_left = literal_left - 32'd1;
                if (literal_left == 32'd0)
                    phase = EXPECT_FLAG;
            end
            EXPECT_RUN_VALUE:
            begin
                // an empty run swallows its value byte silently
                if (block_len != 32'd0)
                begin
                    produced = 1'b1;
                    res.repeat_count = block_len;
                end
                phase = EXPECT_FLAG;
            end
            default:
            begin
                run_block = (it.encoded_byte != 8'd0);
                block_len = 32'd0;
                literal_left = 32'd0;
                phase = EXPECT_LEN0;
            end
        endcase
        // end of buffer drops any partial block
        if (it.last_in_buffer)
        begin
            phase = EXPECT_FLAG;
            literal_left = 32'd0;
        end
        if (produced)
            decoded_q = {decoded_q, res};
    endtask

    // compare one popped transaction against the oldest prediction
    task automatic check_result(input out_item_t got);
        out_item_t want;
        if (decoded_q.size() == 0)
        begin
            $error("unexpected result: data_value %0h repeat_count %0d buffer_end %0b",
                   got.data_value, got.repeat_count, got.buffer_end);
            mismatches++;
        end
        else
        begin
            want = decoded_q.pop_front();
            if (got.data_value !== want.data_value)
            begin
                $error("data_value: expected %0h, got %0h", want.data_value, got.data_value);
                mismatches++;
            end
            if (got.repeat_count !== want.repeat_count)
            begin
                $error("repeat_count: expected %0d, got %0d",
                       want.repeat_count, got.repeat_count);
                mismatches++;
            end
            if (got.buffer_end !== want.buffer_end)
            begin
                $error("buffer_end: expected %0b, got %0b", want.buffer_end, got.buffer_end);
                mismatches++;
            end
        end
    endtask

    // sample both ports at each edge, before the block updates its outputs
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase = EXPECT_FLAG;
            run_block = 1'b0;
            block_len = 32'd0;
            literal_left = 32'd0;
            decoded_q.delete();
            backlog <= 0;
        end
        else
        begin
            if (pop && !empty)
                check_result(decoded);
            if (push && !full)
                decode_byte(encoded);
            backlog <= decoded_q.size();
        end
    end

endmodule

// ===== verif/run_length_block_decoder_core_tb.sv =====
// run_length_block_decoder_core_tb: stimulus, idling and verdict for the run-length decoder
// depends on rlbd_pkg, run_length_block_decoder_core and run_length_block_decoder_checker
`timescale 1ns / 1ps

module run_length_block_decoder_core_tb;

    import rlbd_pkg::*;

    localparam int unsigned ITEM_TARGET = 950;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        pop = 1'b0;
    logic        full;
    logic        empty;
    in_item_t    encoded = '0;
    out_item_t   decoded;
    int unsigned backlog;
    int unsigned error_count;
    int unsigned items_sent = 0;

    run_length_block_decoder_core dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .encoded (encoded),
        .empty   (empty),
        .pop     (pop),
        .decoded (decoded)
    );

    run_length_block_decoder_checker scoreboard (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .encoded     (encoded),
        .empty       (empty),
        .pop         (pop),
        .decoded     (decoded),
        .backlog     (backlog),
        .error_count (error_count)
    );

    always #2 clk = ~clk;

    // idle length: mostly none or short, now and then long
    function automatic int pick_gap(input bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // offer one byte after a random gap and hold it until the block takes it
    task automatic put_byte(input logic [7:0] value, input logic last);
        int gap;
        gap = pick_gap((items_sent % 128) < 24);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        encoded <= '{encoded_byte: value, last_in_buffer: last};
        @(posedge clk);
        while (full)
            @(posedge clk);
        items_sent++;
    endtask

    // flag byte and little-endian length, none marked last
    task automatic put_header(input logic [7:0] flag, input logic [31:0] len);
        put_byte(flag, 1'b0);
        for (int i = 0; i < 4; i++)
            put_byte(len[8*i +: 8], 1'b0);
    endtask

    function automatic logic [31:0] pick_run_length();
        case ($urandom_range(0, 3))
            0: return $urandom_range(1, 16);
            1: return $urandom();
            2: return 32'($urandom_range(1, 255)) << (8 * $urandom_range(0, 3));
            default: return ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'd1;
        endcase
    endfunction

    // receiver: random pop gaps and bursts, with two long hold-offs to fill the block
    initial
    begin : receiver
        int gap;
        int burst;
        int cycle_cnt;
        int long_holds;
        cycle_cnt = 0;
        long_holds = 0;
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if ((cycle_cnt >= 500 && long_holds == 0) || (cycle_cnt >= 2000 && long_holds == 1))
            begin
                pop <= 1'b0;
                repeat (300) @(posedge clk);
                cycle_cnt += 300;
                long_holds++;
            end
            gap = pick_gap(((cycle_cnt / 256) % 4) == 3);
            if (gap > 0)
            begin
                pop <= 1'b0;
                repeat (gap) @(posedge clk);
                cycle_cnt += gap;
            end
            burst = $urandom_range(1, 8);
            pop <= 1'b1;
            repeat (burst) @(posedge clk);
            cycle_cnt += burst;
        end
    end

    // run limit
    initial
    begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // stimulus and verdict
    initial
    begin : stimulus
        int          kind;
        int          n;
        logic [31:0] len;
        logic        last;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // literal block of five cut short after three bytes, extreme values, end with result
        put_header(8'h00, 32'd5);
        put_byte(8'h00, 1'b0);
        put_byte(8'hFF, 1'b0);
        put_byte(8'hA5, 1'b1);
        // longest run, zero value
        put_header(8'hFF, 32'hFFFF_FFFF);
        put_byte(8'h00, 1'b0);
        // empty run ending the buffer: value consumed, no result, end mark lost
        put_header(8'h01, 32'd0);
        put_byte(8'hFF, 1'b1);
        // empty literal block goes straight back to the flag
        put_header(8'h00, 32'd0);

        // random blocks, mostly well formed
        while (items_sent < ITEM_TARGET)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 40)
            begin
                // literal block
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
                last = ($urandom_range(0, 99) < 15);
                put_header(8'h00, len);
                for (int i = 0; i < len; i++)
                    put_byte(8'($urandom_range(0, 255)), last && (i == len - 1));
            end
            else if (kind < 75)
            begin
                // run block
                put_header(8'($urandom_range(1, 255)), pick_run_length());
                put_byte(8'($urandom_range(0, 255)), $urandom_range(0, 99) < 15);
            end
            else if (kind < 80)
            begin
                // empty block of either kind
                if ($urandom_range(0, 1) != 0)
                begin
                    put_header(8'($urandom_range(1, 255)), 32'd0);
                    put_byte(8'($urandom_range(0, 255)), $urandom_range(0, 1) != 0);
                end
                else
                    put_header(8'h00, 32'd0);
            end
            else if (kind < 87)
            begin
                // literal block, mostly cut short by end of buffer
                len = ($urandom_range(0, 1) != 0) ? $urandom() : $urandom_range(2, 10);
                put_header(8'h00, len);
                n = $urandom_range(0, 3);
                for (int i = 0; i < n; i++)
                    put_byte(8'($urandom_range(0, 255)), 1'b0);
                put_byte(8'($urandom_range(0, 255)), 1'b1);
            end
            else if (kind < 92)
            begin
                // header cut short by end of buffer
                n = $urandom_range(0, 3);
                put_byte(8'($urandom_range(0, 255)), n == 0);
                for (int i = 1; i <= n; i++)
                    put_byte(8'($urandom_range(0, 255)), i == n);
            end
            else
            begin
                // noise, then an end of buffer to resync
                n = $urandom_range(1, 6);
                for (int i = 0; i < n; i++)
                    put_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
                put_byte(8'($urandom_range(0, 255)), 1'b1);
            end
        end
        push <= 1'b0;

        // drain, then allow for the pipeline
        @(posedge clk);
        while (backlog != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        @(negedge clk);

        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== run_length_block_decoder_core.f =====
sv/rlbd_pkg.sv
sv/rlbd_front.sv
sv/rlbd_queue.sv
sv/rlbd_back.sv
sv/run_length_block_decoder_core.sv
sv/rlbd_checker.sv
verif/run_length_block_decoder_checker.sv
verif/run_length_block_decoder_core_tb.sv
